// ===== hdl/rhmw_pkg.sv =====
// Shared constants and types for the right-hand maze walker.
// No dependencies; imported by the core, its engine and the port checker.
package rhmw_pkg;

   localparam int GRID_SIZE = 16;
   localparam int CRD_W     = 4;
   localparam int HD_W      = 2;
   localparam int ADDR_W    = $clog2(GRID_SIZE * GRID_SIZE);
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 16;

   localparam logic [CRD_W-1:0] CRD_LAST = CRD_W'(GRID_SIZE - 1);

   localparam logic [HD_W-1:0] HD_NORTH = 2'd0;
   localparam logic [HD_W-1:0] HD_EAST  = 2'd1;
   localparam logic [HD_W-1:0] HD_SOUTH = 2'd2;
   localparam logic [HD_W-1:0] HD_WEST  = 2'd3;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_STEP  = 1'b1;

   localparam logic CSR_START_ROW = 1'b0;
   localparam logic CSR_START_COL = 1'b1;

   typedef struct packed {
      logic             write;
      logic             step;
      logic [CRD_W-1:0] cell_row;
      logic [CRD_W-1:0] cell_col;
      logic             cell_wall;
   } rhmw_cmd_type;

   typedef struct packed {
      logic idle;
      logic done;
   } rhmw_stat_type;

   typedef struct packed {
      logic             at_exit;
      logic [HD_W-1:0]  heading;
      logic [CRD_W-1:0] pos_col;
      logic [CRD_W-1:0] pos_row;
   } rhmw_res_type;

   function automatic logic on_border(logic [CRD_W-1:0] r, logic [CRD_W-1:0] c);
      return (r == '0) || (c == '0) || (r == CRD_LAST) || (c == CRD_LAST);
   endfunction

endpackage

// ===== hdl/right_hand_maze_walker_core.sv =====
// Right-hand maze walker: stream ports, start registers and result register.
// Depends on rhmw_pkg and rhmw_engine.
//
// A write transaction stores one wall bit; the block is ready again in the
// next cycle and returns nothing. A step transaction returns one result. The
// first step, and a step while standing on the border, goes from acceptance to
// the S_DONE state and, once the result register is free, into the result
// register. An interior step probes the right, straight and left cells one per
// cycle through the wall RAM's single read port before S_DONE. A new item is
// taken while an earlier result still waits on rsp_tready. The wall RAM has no
// reset; cells must be written before the walk reads them.
module right_hand_maze_walker_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [3:0] cell_row, [7:4] cell_col, [8] cell_wall, [15:9] zero
   input  logic [rhmw_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // [0] req_type
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [3:0] pos_row, [7:4] pos_col, [9:8] heading, [10] at_exit, [15:11] zero
   output logic [rhmw_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic                               csr_index,
   input  logic [rhmw_pkg::CRD_W-1:0]         csr_data
);
   import rhmw_pkg::*;

   logic [CRD_W-1:0]       start_row_ff, start_col_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;
   logic                   req_acc, take;
   rhmw_cmd_type           cmd;
   rhmw_stat_type          stat;
   rhmw_res_type           res;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_row_ff <= '0;
         start_col_ff <= CRD_W'(1);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_START_ROW: start_row_ff <= csr_data;
            CSR_START_COL: start_col_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_tready    = stat.idle;
   assign req_acc       = req_tvalid && req_tready;
   assign cmd.write     = req_acc && (req_tuser == REQ_WRITE);
   assign cmd.step      = req_acc && (req_tuser == REQ_STEP);
   assign cmd.cell_row  = req_tdata[CRD_W-1:0];
   assign cmd.cell_col  = req_tdata[2*CRD_W-1:CRD_W];
   assign cmd.cell_wall = req_tdata[2*CRD_W];

   rhmw_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .start_row (start_row_ff),
      .start_col (start_col_ff),
      .take      (take),
      .stat      (stat),
      .res       (res)
   );

   assign take = stat.done && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take)            rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (take) rsp_data_ff <= RSP_TDATA_W'(res);
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== hdl/rhmw_engine.sv =====
// Walker engine: wall RAM (one write, one registered read port), position state
// and the step sequencer that probes one candidate cell per cycle. Uses rhmw_pkg.
module rhmw_engine (
   input  logic                           clock,
   input  logic                           reset,
   input  rhmw_pkg::rhmw_cmd_type         cmd,
   input  logic [rhmw_pkg::CRD_W-1:0]     start_row,
   input  logic [rhmw_pkg::CRD_W-1:0]     start_col,
   input  logic                           take,
   output rhmw_pkg::rhmw_stat_type        stat,
   output rhmw_pkg::rhmw_res_type         res
);
   import rhmw_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_PROBE, S_DONE} state_type;

   state_type        state_ff;
   logic [CRD_W-1:0] row_ff, col_ff;
   logic [HD_W-1:0]  hd_ff;
   logic             started_ff;
   logic [HD_W-1:0]  cand_ff;
   logic [1:0]       tries_ff;
   logic             wall_rd_ff;

   logic             wall_mem [GRID_SIZE*GRID_SIZE];

   logic [HD_W-1:0]  probe_hd;
   logic [CRD_W-1:0] probe_row, probe_col;
   logic [CRD_W-1:0] cand_row, cand_col;
   logic [CRD_W-1:0] sat_row, sat_col;
   logic [HD_W-1:0]  start_hd;
   logic [CRD_W-1:0] first_row, first_col;
   logic             wr_ok;

   function automatic logic [2*CRD_W-1:0] neighbor(logic [CRD_W-1:0] r,
                                                   logic [CRD_W-1:0] c,
                                                   logic [HD_W-1:0]  h);
      logic [CRD_W-1:0] nr;
      logic [CRD_W-1:0] nc;
      nr = r;
      nc = c;
      unique case (h)
         HD_NORTH: if (r != '0)       nr = r - 1'b1;
         HD_EAST:  if (c != CRD_LAST) nc = c + 1'b1;
         HD_SOUTH: if (r != CRD_LAST) nr = r + 1'b1;
         default:  if (c != '0)       nc = c - 1'b1;
      endcase
      return {nr, nc};
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(logic [CRD_W-1:0] r,
                                                   logic [CRD_W-1:0] c);
      return ADDR_W'(ADDR_W'(r) * ADDR_W'(GRID_SIZE) + ADDR_W'(c));
   endfunction

   // first probe is to the right of the heading, each further one a quarter turn left
   assign probe_hd = (state_ff == S_IDLE) ? hd_ff + 1'b1 : cand_ff - 1'b1;
   assign {probe_row, probe_col} = neighbor(row_ff, col_ff, probe_hd);
   assign {cand_row, cand_col}   = neighbor(row_ff, col_ff, cand_ff);

   assign sat_row = (int'(start_row) > GRID_SIZE - 1) ? CRD_LAST : start_row;
   assign sat_col = (int'(start_col) > GRID_SIZE - 1) ? CRD_LAST : start_col;

   always_comb begin
      priority if (sat_row == '0)       start_hd = HD_SOUTH;
      else if (sat_row == CRD_LAST)     start_hd = HD_NORTH;
      else if (sat_col == '0)           start_hd = HD_EAST;
      else if (sat_col == CRD_LAST)     start_hd = HD_WEST;
      else                              start_hd = HD_SOUTH;
   end
   assign {first_row, first_col} = neighbor(sat_row, sat_col, start_hd);

   assign wr_ok = cmd.write && (int'(cmd.cell_row) < GRID_SIZE)
                  && (int'(cmd.cell_col) < GRID_SIZE);

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         wall_mem[cell_addr(cmd.cell_row, cmd.cell_col)] <= cmd.cell_wall;
      end
      wall_rd_ff <= wall_mem[cell_addr(probe_row, probe_col)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         row_ff     <= '0;
         col_ff     <= '0;
         hd_ff      <= HD_SOUTH;
         started_ff <= 1'b0;
         cand_ff    <= '0;
         tries_ff   <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (cmd.step) begin
                  if (!started_ff) begin
                     row_ff     <= first_row;
                     col_ff     <= first_col;
                     hd_ff      <= start_hd;
                     started_ff <= 1'b1;
                     state_ff   <= S_DONE;
                  end else if (on_border(row_ff, col_ff)) begin
                     state_ff <= S_DONE;
                  end else begin
                     cand_ff  <= probe_hd;
                     tries_ff <= '0;
                     state_ff <= S_PROBE;
                  end
               end
            end
            S_PROBE: begin
               if (!wall_rd_ff) begin
                  row_ff   <= cand_row;
                  col_ff   <= cand_col;
                  hd_ff    <= cand_ff;
                  state_ff <= S_DONE;
               end else if (tries_ff == 2'd2) begin
                  // right, straight and left blocked: step back
                  row_ff   <= probe_row;
                  col_ff   <= probe_col;
                  hd_ff    <= probe_hd;
                  state_ff <= S_DONE;
               end else begin
                  cand_ff  <= probe_hd;
                  tries_ff <= tries_ff + 1'b1;
               end
            end
            S_DONE: begin
               if (take) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign stat.idle   = (state_ff == S_IDLE);
   assign stat.done   = (state_ff == S_DONE);
   assign res.pos_row = row_ff;
   assign res.pos_col = col_ff;
   assign res.heading = hd_ff;
   assign res.at_exit = on_border(row_ff, col_ff);

endmodule

// ===== hdl/rhmw_checker.sv =====
// Port-level checks for right_hand_maze_walker_core, bound to the top level.
// Depends on rhmw_pkg.
module rhmw_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               req_tuser,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [rhmw_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import rhmw_pkg::*;

   logic [CRD_W-1:0] r_row, r_col;
   assign r_row = rsp_tdata[CRD_W-1:0];
   assign r_col = rsp_tdata[2*CRD_W-1:CRD_W];

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_exit_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[2*CRD_W+HD_W] == on_border(r_row, r_col)))
      else $error("at_exit disagrees with position");

   // a wall write never stalls the next item
   a_write_quick: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == REQ_WRITE) |=> req_tready)
      else $error("not ready after write");

   a_step_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == REQ_STEP) |=> !req_tready)
      else $error("ready right after step");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind right_hand_maze_walker_core rhmw_checker u_rhmw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
